// File: rtl/core/ils_pkg.sv
// ils_pkg: shared types and codes for the indexed list store
// command, result kind and operation codes, queue word layout
// no dependencies
package ils_pkg;

   // default and largest list capacity
   localparam int ILS_CAPACITY = 32;
   localparam int CAPACITY_MAX = 64;

   // port field widths
   localparam int CMD_W   = 3;
   localparam int POS_W   = 6;
   localparam int KIND_W  = 3;
   localparam int VALUE_W = 32;

   // width of a count field in the queue word, wide enough for the largest capacity
   localparam int ENT_CNT_W = $clog2(CAPACITY_MAX + 1);

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // command codes
   localparam logic [CMD_W-1:0] CMD_PRINT  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_MIN    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_DELETE = 3'd2;
   localparam logic [CMD_W-1:0] CMD_APPEND = 3'd3;
   localparam logic [CMD_W-1:0] CMD_INSERT = 3'd4;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_ELEM    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_EMPTY   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_INDEX   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_FULL    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_MIN     = 3'd4;
   localparam logic [KIND_W-1:0] KIND_REMOVED = 3'd5;
   localparam logic [KIND_W-1:0] KIND_DELFAIL = 3'd6;

   // work the back end carries out
   typedef enum logic [2:0] {
      OP_SINGLE,
      OP_PRINT,
      OP_MIN,
      OP_DEL,
      OP_INS
   } op_type;

   // one classified command; cnt is the element count after the command
   typedef struct packed {
      op_type                    op;
      logic [KIND_W-1:0]         kind;
      logic [POS_W-1:0]          pos;
      logic [ENT_CNT_W-1:0]      cnt;
      logic signed [VALUE_W-1:0] value;
   } entry_type;

endpackage

// File: rtl/core/ils_if.sv
// ils_req_if, ils_rsp_if: valid/ready channels of the indexed list store
// depends on ils_pkg for field widths
interface ils_req_if;
   import ils_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [CMD_W-1:0]          cmd;
   logic [POS_W-1:0]          position;
   logic signed [VALUE_W-1:0] item_value;

   modport source (output valid, cmd, position, item_value, input ready);
   modport sink   (input valid, cmd, position, item_value, output ready);
endinterface

interface ils_rsp_if;
   import ils_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [KIND_W-1:0]         kind;
   logic signed [VALUE_W-1:0] value;
   logic                      last;

   modport source (output valid, kind, value, last, input ready);
   modport sink   (input valid, kind, value, last, output ready);
endinterface

// File: rtl/core/ils_ram.sv
// ils_ram: generic one write port, one read port ram with registered read
// no dependencies
module ils_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/core/ils_front.sv
// ils_front: accepts command words, tracks the element count and classifies
// each command into a queue word; depends on ils_pkg and ils_req_if
module ils_front #(
   parameter int CAPACITY = ils_pkg::ILS_CAPACITY
) (
   input  logic                            clock,
   input  logic                            reset,
   ils_req_if.sink                         req_ch,
   input  logic                            q_full,
   output logic                            q_push,
   output ils_pkg::entry_type              q_entry,
   output logic [ils_pkg::ENT_CNT_W-1:0]   fill_count
);
   import ils_pkg::*;

   localparam int CW    = $clog2(CAPACITY + 1);
   localparam int CMP_W = CW + POS_W;

   logic [CW-1:0]    cnt_ff, cnt_in, cnt_nxt;
   logic [CMP_W-1:0] pos_x, cnt_x, cap_x;
   logic             take, known;
   entry_type        entry;

   assign pos_x = CMP_W'(req_ch.position);
   assign cnt_x = CMP_W'(cnt_ff);
   assign cap_x = CMP_W'(CAPACITY);

   // classify against the count left by all earlier commands
   always_comb begin
      entry.op    = OP_SINGLE;
      entry.kind  = KIND_EMPTY;
      entry.pos   = req_ch.position;
      entry.cnt   = ENT_CNT_W'(cnt_ff);
      entry.value = '0;
      known       = 1'b1;
      cnt_nxt     = cnt_ff;
      case (req_ch.cmd)
         CMD_PRINT: begin
            if (cnt_ff != '0) begin
               entry.op = OP_PRINT;
            end
         end
         CMD_MIN: begin
            if (cnt_ff != '0) begin
               entry.op = OP_MIN;
            end
         end
         CMD_DELETE: begin
            if (pos_x >= cnt_x) begin
               entry.kind  = KIND_DELFAIL;
               entry.value = '1;
            end else begin
               entry.op  = OP_DEL;
               cnt_nxt   = CW'(cnt_ff - 1'b1);
               entry.cnt = ENT_CNT_W'(cnt_nxt);
            end
         end
         CMD_APPEND: begin
            if (cnt_x >= cap_x) begin
               entry.kind = KIND_FULL;
            end else begin
               entry.op    = OP_INS;
               entry.pos   = POS_W'(cnt_ff);
               entry.value = req_ch.item_value;
               cnt_nxt     = CW'(cnt_ff + 1'b1);
               entry.cnt   = ENT_CNT_W'(cnt_nxt);
            end
         end
         CMD_INSERT: begin
            if (pos_x > cnt_x) begin
               entry.kind = KIND_INDEX;
            end else if (cnt_x >= cap_x) begin
               entry.kind = KIND_FULL;
            end else begin
               entry.op    = OP_INS;
               entry.value = req_ch.item_value;
               cnt_nxt     = CW'(cnt_ff + 1'b1);
               entry.cnt   = ENT_CNT_W'(cnt_nxt);
            end
         end
         default: begin
            known = 1'b0;
         end
      endcase
   end

   // handshake and push into the queue
   assign req_ch.ready = !q_full;
   assign take         = req_ch.valid && req_ch.ready;
   assign q_push       = take && known;
   assign q_entry      = entry;
   assign cnt_in       = take ? cnt_nxt : cnt_ff;
   assign fill_count   = ENT_CNT_W'(cnt_ff);

   // element count
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

// File: rtl/core/ils_queue.sv
// ils_queue: short fifo of classified commands between front and back
// depends on ils_pkg
module ils_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ils_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output ils_pkg::entry_type pop_entry,
   output logic               empty
);
   import ils_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int OW = $clog2(QUEUE_DEPTH + 1);

   entry_type       slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [OW-1:0]   occ_ff, occ_in;

   assign full      = (occ_ff == OW'(QUEUE_DEPTH));
   assign empty     = (occ_ff == '0);
   assign pop_entry = slot_ff[rd_ptr_ff];

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      occ_in    = occ_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : PW'(wr_ptr_ff + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : PW'(rd_ptr_ff + 1'b1);
      end
      if (push && !pop) begin
         occ_in = OW'(occ_ff + 1'b1);
      end else if (pop && !push) begin
         occ_in = OW'(occ_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         occ_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         occ_ff    <= occ_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: rtl/core/ils_back.sv
// ils_back: carries out queued commands on the element ram, sweeping it
// one entry a cycle while the result side does not stall, and drives the result register
// depends on ils_pkg, ils_rsp_if and ils_ram
module ils_back #(
   parameter int CAPACITY = ils_pkg::ILS_CAPACITY
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_empty,
   input  ils_pkg::entry_type q_entry,
   output logic               q_pop,
   ils_rsp_if.source          rsp_ch
);
   import ils_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_PRINT,
      S_MIN,
      S_DEL,
      S_INS,
      S_WRVAL,
      S_EMIT
   } state_type;

   state_type                 state_ff, state_in;
   logic [AW-1:0]             rd_addr_ff, rd_addr_in;
   logic [CW-1:0]             rd_left_ff, rd_left_in;
   logic                      issued_ff, issued_in;
   logic                      pend_ff, pend_in;
   logic [AW-1:0]             pend_addr_ff, pend_addr_in;
   logic                      pend_last_ff, pend_last_in;
   logic                      pend_first_ff, pend_first_in;
   logic [CW-1:0]             cur_cnt_ff, cur_cnt_in;
   logic [AW-1:0]             cur_pos_ff, cur_pos_in;
   logic signed [VALUE_W-1:0] cur_value_ff, cur_value_in;
   logic signed [VALUE_W-1:0] best_ff, best_in;
   logic [KIND_W-1:0]         res_kind_ff, res_kind_in;
   logic signed [VALUE_W-1:0] res_value_ff, res_value_in;
   logic                      out_v_ff, out_v_in;
   logic [KIND_W-1:0]         out_kind_ff, out_kind_in;
   logic signed [VALUE_W-1:0] out_value_ff, out_value_in;
   logic                      out_last_ff, out_last_in;

   logic                      we, re;
   logic [AW-1:0]             waddr, raddr;
   logic [VALUE_W-1:0]        wdata, rdata;
   logic signed [VALUE_W-1:0] rdata_s, cand;
   logic                      taken, out_free, sweeping, consume, issue;
   logic [CW-1:0]             e_cnt, e_pos, ins_n;

   // element storage
   ils_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .re    (re),
      .raddr (raddr),
      .rdata (rdata)
   );

   assign rdata_s  = $signed(rdata);
   assign taken    = out_v_ff && rsp_ch.ready;
   assign out_free = !out_v_ff || taken;
   assign sweeping = (state_ff == S_PRINT) || (state_ff == S_MIN) ||
                     (state_ff == S_DEL) || (state_ff == S_INS);
   assign consume  = pend_ff && ((state_ff != S_PRINT) || out_free);
   assign issue    = sweeping && (rd_left_ff != '0) && (!pend_ff || consume);
   assign cand     = (pend_first_ff || (rdata_s < best_ff)) ? rdata_s : best_ff;
   assign e_cnt    = CW'(q_entry.cnt);
   assign e_pos    = CW'(q_entry.pos);
   assign ins_n    = CW'(e_cnt - 1'b1 - e_pos);

   // sequencer: read sweep, data handling and result register
   always_comb begin
      state_in      = state_ff;
      rd_addr_in    = rd_addr_ff;
      rd_left_in    = rd_left_ff;
      issued_in     = issued_ff;
      pend_in       = pend_ff;
      pend_addr_in  = pend_addr_ff;
      pend_last_in  = pend_last_ff;
      pend_first_in = pend_first_ff;
      cur_cnt_in    = cur_cnt_ff;
      cur_pos_in    = cur_pos_ff;
      cur_value_in  = cur_value_ff;
      best_in       = best_ff;
      res_kind_in   = res_kind_ff;
      res_value_in  = res_value_ff;
      out_v_in      = out_v_ff && !taken;
      out_kind_in   = out_kind_ff;
      out_value_in  = out_value_ff;
      out_last_in   = out_last_ff;
      q_pop         = 1'b0;
      we            = 1'b0;
      waddr         = pend_addr_ff;
      wdata         = rdata;
      re            = 1'b0;
      raddr         = rd_addr_ff;

      // data of the pending read, held in the ram read register
      if (consume) begin
         pend_in = 1'b0;
         case (state_ff)
            S_PRINT: begin
               out_v_in     = 1'b1;
               out_kind_in  = KIND_ELEM;
               out_value_in = rdata_s;
               out_last_in  = pend_last_ff;
               if (pend_last_ff) begin
                  state_in = S_IDLE;
               end
            end
            S_MIN: begin
               best_in = cand;
               if (pend_last_ff) begin
                  res_kind_in  = KIND_MIN;
                  res_value_in = cand;
                  state_in     = S_EMIT;
               end
            end
            S_DEL: begin
               if (pend_first_ff) begin
                  res_value_in = rdata_s;
               end else begin
                  we    = 1'b1;
                  waddr = AW'(pend_addr_ff - 1'b1);
               end
               if (pend_last_ff) begin
                  res_kind_in = KIND_REMOVED;
                  state_in    = S_EMIT;
               end
            end
            S_INS: begin
               we    = 1'b1;
               waddr = AW'(pend_addr_ff + 1'b1);
               if (pend_last_ff) begin
                  state_in = S_WRVAL;
               end
            end
            default: begin
            end
         endcase
      end

      // next read of the sweep, downward for insert
      if (issue) begin
         re            = 1'b1;
         rd_addr_in    = (state_ff == S_INS) ? AW'(rd_addr_ff - 1'b1)
                                             : AW'(rd_addr_ff + 1'b1);
         rd_left_in    = CW'(rd_left_ff - 1'b1);
         issued_in     = 1'b1;
         pend_in       = 1'b1;
         pend_addr_in  = rd_addr_ff;
         pend_last_in  = (rd_left_ff == CW'(1));
         pend_first_in = !issued_ff;
      end

      case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               q_pop        = 1'b1;
               issued_in    = 1'b0;
               cur_cnt_in   = e_cnt;
               cur_pos_in   = AW'(q_entry.pos);
               cur_value_in = q_entry.value;
               rd_addr_in   = '0;
               rd_left_in   = e_cnt;
               case (q_entry.op)
                  OP_PRINT: state_in = S_PRINT;
                  OP_MIN:   state_in = S_MIN;
                  OP_DEL: begin
                     rd_addr_in = AW'(q_entry.pos);
                     rd_left_in = CW'(e_cnt + 1'b1 - e_pos);
                     state_in   = S_DEL;
                  end
                  OP_INS: begin
                     rd_addr_in = AW'(e_cnt - CW'(2));
                     rd_left_in = ins_n;
                     state_in   = (ins_n == '0) ? S_WRVAL : S_INS;
                  end
                  default: begin
                     res_kind_in  = q_entry.kind;
                     res_value_in = q_entry.value;
                     state_in     = S_EMIT;
                  end
               endcase
            end
         end
         S_WRVAL: begin
            we         = 1'b1;
            waddr      = cur_pos_ff;
            wdata      = cur_value_ff;
            rd_addr_in = '0;
            rd_left_in = cur_cnt_ff;
            issued_in  = 1'b0;
            state_in   = S_PRINT;
         end
         S_EMIT: begin
            if (out_free) begin
               out_v_in     = 1'b1;
               out_kind_in  = res_kind_ff;
               out_value_in = res_value_ff;
               out_last_in  = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         pend_ff   <= 1'b0;
         issued_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         pend_ff   <= pend_in;
         issued_ff <= issued_in;
         out_v_ff  <= out_v_in;
      end
      rd_addr_ff    <= rd_addr_in;
      rd_left_ff    <= rd_left_in;
      pend_addr_ff  <= pend_addr_in;
      pend_last_ff  <= pend_last_in;
      pend_first_ff <= pend_first_in;
      cur_cnt_ff    <= cur_cnt_in;
      cur_pos_ff    <= cur_pos_in;
      cur_value_ff  <= cur_value_in;
      best_ff       <= best_in;
      res_kind_ff   <= res_kind_in;
      res_value_ff  <= res_value_in;
      out_kind_ff   <= out_kind_in;
      out_value_ff  <= out_value_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_ch.valid = out_v_ff;
   assign rsp_ch.kind  = out_kind_ff;
   assign rsp_ch.value = out_value_ff;
   assign rsp_ch.last  = out_last_ff;

endmodule

// File: rtl/core/indexed_list_store_core.sv
// indexed_list_store_core: ordered list of signed words with print, min, delete, append, insert
// with n the count before the command: min sweeps the list, delete at p reads entries p to
// n - 1 and moves each later one up, print sends the first element, then one a cycle while
// the result side does not stall; append writes the new word before printing, insert at p < n
// first shifts entries p to n - 1 down; one command at a time through the single ram read port,
// result stalls hold it up; reset clears the count, the queue and the result register; ram contents are kept
module indexed_list_store_core #(
   parameter int CAPACITY = ils_pkg::ILS_CAPACITY
) (
   input  logic      clock,
   input  logic      reset,
   ils_req_if.sink   req_ch,
   ils_rsp_if.source rsp_ch
);
   import ils_pkg::*;

   logic                 q_push, q_pop, q_full, q_empty;
   entry_type            push_entry, pop_entry;
   logic [ENT_CNT_W-1:0] fill_count;

   // classify incoming command words
   ils_front #(
      .CAPACITY (CAPACITY)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (push_entry),
      .fill_count (fill_count)
   );

   // decoupling queue
   ils_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .pop_entry  (pop_entry),
      .empty      (q_empty)
   );

   // execute on the element ram
   ils_back #(
      .CAPACITY (CAPACITY)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_entry (pop_entry),
      .q_pop   (q_pop),
      .rsp_ch  (rsp_ch)
   );

   // queue never overflows or underflows
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("pop from empty queue");

   // tracked count stays within capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      fill_count <= ENT_CNT_W'(CAPACITY))
      else $error("element count beyond capacity");

endmodule

// File: test/ils_list_checker.sv
// ils_list_checker: watches both channels of the indexed list store, keeps its own copy of
// the list, predicts every result word and compares it with the word the block sends
// depends on ils_pkg and the channel interfaces in ils_if.sv
module ils_list_checker #(
   parameter int CAPACITY = ils_pkg::ILS_CAPACITY
) (
   input  logic clock,
   input  logic reset,
   ils_req_if   req_mon,
   ils_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending_words,
   output int   list_len
);
   import ils_pkg::*;

   typedef struct {
      logic [KIND_W-1:0]         kind;
      logic signed [VALUE_W-1:0] value;
      logic                      last;
   } result_word_type;

   logic signed [VALUE_W-1:0] shadow_list [CAPACITY];
   int                        shadow_len;
   result_word_type           expected_words [$];

   function automatic void expect_word(input logic [KIND_W-1:0] kind,
                                       input logic signed [VALUE_W-1:0] value,
                                       input logic last);
      result_word_type w;
      w.kind  = kind;
      w.value = value;
      w.last  = last;
      expected_words.push_back(w);
   endfunction

   // whole list front first, or a single empty marker
   function automatic void expect_list_dump();
      if (shadow_len == 0) begin
         expect_word(KIND_EMPTY, '0, 1'b1);
      end else begin
         for (int i = 0; i < shadow_len; i++)
            expect_word(KIND_ELEM, shadow_list[i], (i + 1 == shadow_len));
      end
   endfunction

   function automatic void put_at(input int slot, input logic signed [VALUE_W-1:0] v);
      for (int i = shadow_len; i > slot; i--)
         shadow_list[i] = shadow_list[i-1];
      shadow_list[slot] = v;
      shadow_len++;
   endfunction

   // update the list copy for one command and queue the words it should produce
   function automatic void predict_list_words(input logic [CMD_W-1:0] cmd,
                                              input logic [POS_W-1:0] pos,
                                              input logic signed [VALUE_W-1:0] v);
      logic signed [VALUE_W-1:0] low;
      logic signed [VALUE_W-1:0] gone;
      int                        slot;
      slot = int'(pos);
      case (cmd)
         CMD_PRINT: begin
            expect_list_dump();
         end
         CMD_MIN: begin
            if (shadow_len == 0) begin
               expect_word(KIND_EMPTY, '0, 1'b1);
            end else begin
               low = shadow_list[0];
               for (int i = 1; i < shadow_len; i++)
                  if (shadow_list[i] < low) low = shadow_list[i];
               expect_word(KIND_MIN, low, 1'b1);
            end
         end
         CMD_DELETE: begin
            if (slot >= shadow_len) begin
               expect_word(KIND_DELFAIL, -32'sd1, 1'b1);
            end else begin
               gone = shadow_list[slot];
               for (int i = slot; i + 1 < shadow_len; i++)
                  shadow_list[i] = shadow_list[i+1];
               shadow_len--;
               expect_word(KIND_REMOVED, gone, 1'b1);
            end
         end
         CMD_APPEND: begin
            if (shadow_len >= CAPACITY) begin
               expect_word(KIND_FULL, '0, 1'b1);
            end else begin
               put_at(shadow_len, v);
               expect_list_dump();
            end
         end
         CMD_INSERT: begin
            // index check comes before the full check
            if (slot > shadow_len) begin
               expect_word(KIND_INDEX, '0, 1'b1);
            end else if (shadow_len >= CAPACITY) begin
               expect_word(KIND_FULL, '0, 1'b1);
            end else begin
               put_at(slot, v);
               expect_list_dump();
            end
         end
         default: begin
            // unused command codes are dropped by the block
         end
      endcase
   endfunction

   // compare result words, then account for the accepted command
   always @(posedge clock) begin
      result_word_type want;
      if (reset) begin
         expected_words.delete();
         shadow_len = 0;
         fail_count = 0;
      end else begin
         // a result word always belongs to an earlier command
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_words.size() == 0) begin
               $error("unexpected result word: kind %0d value %0d last %0b",
                      rsp_mon.kind, rsp_mon.value, rsp_mon.last);
               fail_count++;
            end else begin
               want = expected_words.pop_front();
               if (rsp_mon.kind !== want.kind) begin
                  $error("kind mismatch: expected %0d, got %0d", want.kind, rsp_mon.kind);
                  fail_count++;
               end
               if (rsp_mon.value !== want.value) begin
                  $error("value mismatch: expected %0d, got %0d", want.value, rsp_mon.value);
                  fail_count++;
               end
               if (rsp_mon.last !== want.last) begin
                  $error("last mismatch: expected %0b, got %0b", want.last, rsp_mon.last);
                  fail_count++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            predict_list_words(req_mon.cmd, req_mon.position, req_mon.item_value);
      end
      pending_words = expected_words.size();
      list_len      = shadow_len;
   end

endmodule

// File: test/tb_indexed_list_store_core.sv
// tb_indexed_list_store_core: drives commands into the indexed list store with random idle
// and result stalls; ils_list_checker does the prediction and comparison
// depends on ils_pkg, ils_if.sv, indexed_list_store_core and ils_list_checker
module tb_indexed_list_store_core;
   import ils_pkg::*;

   localparam int CAPACITY       = ILS_CAPACITY;
   localparam int RANDOM_ITEMS   = 340;
   localparam int PHASE_ITEMS    = 40;
   localparam int HOLD_CYCLES    = 300;
   localparam int END_CYCLES     = 120;
   localparam int WATCHDOG_LIMIT = 2000;

   localparam logic [CMD_W-1:0]          CMD_LAST_CODE = {CMD_W{1'b1}};
   localparam logic [POS_W-1:0]          POS_TOP       = {POS_W{1'b1}};
   localparam logic signed [VALUE_W-1:0] VAL_MIN       = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] VAL_MAX       = 32'sh7fff_ffff;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_words;
   int   list_len;
   int   quiet_cycles;
   bit   req_calm;
   bit   rsp_hold;

   ils_req_if req_ch ();
   ils_rsp_if rsp_ch ();

   indexed_list_store_core #(.CAPACITY(CAPACITY)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   ils_list_checker #(.CAPACITY(CAPACITY)) list_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .fail_count    (fail_count),
      .pending_words (pending_words),
      .list_len      (list_len)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // mostly short gaps, a few long ones, none at all when calm
   function automatic int idle_gap(input bit calm);
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [VALUE_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return $urandom;
      if (r < 8) return int'($urandom_range(0, 16)) - 8;
      if (r == 8) return $urandom_range(0, 1) ? VAL_MIN : VAL_MAX;
      return $urandom_range(0, 1) ? -32'sd1 : 32'sd0;
   endfunction

   // mostly a valid index, sometimes anything the field holds
   function automatic logic [POS_W-1:0] pick_delete_pos();
      if (list_len == 0 || $urandom_range(0, 99) < 12) return POS_W'($urandom_range(0, POS_TOP));
      return POS_W'($urandom_range(0, list_len - 1));
   endfunction

   function automatic logic [POS_W-1:0] pick_insert_pos();
      if ($urandom_range(0, 99) < 12) return POS_W'($urandom_range(0, POS_TOP));
      return POS_W'($urandom_range(0, list_len));
   endfunction

   // offer one command word and hold it until accepted, then maybe idle
   task automatic send_word(input logic [CMD_W-1:0] op_code, input logic [POS_W-1:0] slot,
                            input logic signed [VALUE_W-1:0] word_value);
      int gap;
      req_ch.cmd        <= op_code;
      req_ch.position   <= slot;
      req_ch.item_value <= word_value;
      req_ch.valid      <= 1'b1;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      @(negedge clock);
      gap = idle_gap(req_calm);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // stop offering until every predicted word has come back
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (pending_words != 0);
   endtask

   // result side ready with random stalls and one long hold-off on request
   initial begin
      int  stall_left;
      bit  rsp_calm;
      stall_left   = 0;
      rsp_calm     = 1'b0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_hold = 1'b0;
            rsp_ch.ready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
            if ($urandom_range(0, 99) < 3) rsp_calm = !rsp_calm;
            stall_left = idle_gap(rsp_calm);
         end
      end
   end

   // watchdog on cycles with no word moving in either direction
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_indexed_list_store_core failed");
         $finish;
      end
   end

   // command stream
   initial begin
      int sent;
      int grow_pct;
      int r;
      req_ch.valid      = 1'b0;
      req_ch.cmd        = CMD_PRINT;
      req_ch.position   = '0;
      req_ch.item_value = '0;
      req_calm          = 1'b0;
      rsp_hold          = 1'b0;
      quiet_cycles      = 0;
      reset             = 1'b1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty list answers
      send_word(CMD_PRINT, '0, '0);
      send_word(CMD_MIN, '0, '0);
      send_word(CMD_DELETE, '0, '0);
      send_word(CMD_INSERT, 6'd1, 32'sd5);
      // insert into an empty list, then min of a single element
      send_word(CMD_INSERT, '0, 32'sd7);
      send_word(CMD_MIN, '0, '0);
      send_word(CMD_APPEND, POS_TOP, VAL_MIN);
      send_word(CMD_APPEND, '0, VAL_MAX);
      // insert at the end behaves as append; past the end is an index error
      send_word(CMD_INSERT, 6'd3, -32'sd1);
      send_word(CMD_INSERT, 6'd5, 32'sd9);
      send_word(CMD_INSERT, 6'd1, 32'sd0);
      send_word(CMD_PRINT, POS_TOP, -32'sd1);
      send_word(CMD_MIN, POS_TOP, VAL_MAX);
      // delete last, out of range, front, far out of range
      send_word(CMD_DELETE, 6'd4, VAL_MIN);
      send_word(CMD_DELETE, 6'd4, '0);
      send_word(CMD_DELETE, '0, '0);
      send_word(CMD_DELETE, POS_TOP, -32'sd1);
      // unused codes leave the list alone
      for (int c = CMD_INSERT + 1; c <= CMD_LAST_CODE; c++)
         send_word(c[CMD_W-1:0], POS_TOP, -32'sd1);
      send_word(CMD_PRINT, '0, '0);
      send_word(CMD_MIN, '0, '0);

      // fill up to capacity, then hit the full cases and an index error past the end
      while (list_len < CAPACITY) begin
         if ($urandom_range(0, 1))
            send_word(CMD_APPEND, POS_W'($urandom_range(0, POS_TOP)), pick_value());
         else send_word(CMD_INSERT, pick_insert_pos(), pick_value());
      end
      send_word(CMD_APPEND, '0, pick_value());
      send_word(CMD_INSERT, '0, pick_value());
      send_word(CMD_INSERT, list_len[POS_W-1:0], pick_value());
      send_word(CMD_INSERT, POS_TOP, pick_value());
      send_word(CMD_MIN, '0, '0);
      send_word(CMD_PRINT, '0, '0);
      // empty it again from random places
      while (list_len > 0) begin
         send_word(CMD_DELETE, pick_delete_pos(), $urandom);
         if ($urandom_range(0, 9) == 0) send_word(CMD_MIN, POS_W'($urandom), $urandom);
      end
      drain_results();

      // long result hold-off while commands keep coming, then a full pause
      rsp_hold = 1'b1;
      for (int i = 0; i < 12; i++) begin
         if (i % 3 == 2) send_word(CMD_PRINT, '0, '0);
         else send_word(CMD_APPEND, '0, pick_value());
      end
      drain_results();

      // random mix in phases that lean toward growing or shrinking the list
      sent     = 0;
      grow_pct = 50;
      while (sent < RANDOM_ITEMS) begin
         if (sent % PHASE_ITEMS == 0) begin
            grow_pct = $urandom_range(15, 85);
            req_calm = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 3) == 0) drain_results();
         end
         r = $urandom_range(0, 99);
         if (r < 3) begin
            send_word(CMD_W'($urandom_range(CMD_INSERT + 1, CMD_LAST_CODE)),
                      POS_W'($urandom), $urandom);
            continue;
         end
         if (r < 11) begin
            send_word(CMD_PRINT, POS_W'($urandom), $urandom);
         end else if (r < 19) begin
            send_word(CMD_MIN, POS_W'($urandom), $urandom);
         end else if ($urandom_range(0, 99) < grow_pct) begin
            if ($urandom_range(0, 1)) send_word(CMD_APPEND, POS_W'($urandom), pick_value());
            else send_word(CMD_INSERT, pick_insert_pos(), pick_value());
         end else begin
            send_word(CMD_DELETE, pick_delete_pos(), $urandom);
         end
         sent++;
      end

      // wind down and give the verdict
      req_calm = 1'b0;
      drain_results();
      repeat (END_CYCLES) @(negedge clock);
      if (fail_count == 0)
         $display("tb_indexed_list_store_core passed");
      else
         $display("tb_indexed_list_store_core failed");
      $finish;
   end

endmodule

// File: files.f
rtl/core/ils_pkg.sv
rtl/core/ils_if.sv
rtl/core/ils_ram.sv
rtl/core/ils_front.sv
rtl/core/ils_queue.sv
rtl/core/ils_back.sv
rtl/core/indexed_list_store_core.sv
test/ils_list_checker.sv
test/tb_indexed_list_store_core.sv
